// ===== hw/rtl/mms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_pkg: shared definitions for the min/max stack
// Operation and status codes, field widths and the shift control bundle
// that the stack cells share.
// ----------------------------------------------------------------------------
package mms_pkg;

   localparam int DATA_W      = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   // Operation codes of a request beat.
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   // Status codes of a response beat.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // Shift command broadcast to every cell of the stack.
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

// ===== hw/rtl/mms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_cell: one entry of the shifting stack
// Holds one word, shifts it toward the bottom on push and toward the top on
// pop, and folds its word into the min/max wave that passes down the chain.
// ----------------------------------------------------------------------------
module mms_cell #(
   parameter int CNT_W = 8
) (
   input  logic                             clock,
   input  mms_pkg::shift_type               shift,
   input  logic signed [mms_pkg::DATA_W-1:0] above_data,
   input  logic signed [mms_pkg::DATA_W-1:0] below_data,
   output logic signed [mms_pkg::DATA_W-1:0] cell_data,
   input  logic signed [mms_pkg::DATA_W-1:0] scan_max_in,
   input  logic signed [mms_pkg::DATA_W-1:0] scan_min_in,
   input  logic        [CNT_W-1:0]           scan_left_in,
   output logic signed [mms_pkg::DATA_W-1:0] scan_max,
   output logic signed [mms_pkg::DATA_W-1:0] scan_min,
   output logic        [CNT_W-1:0]           scan_left
);
   import mms_pkg::*;

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic        [CNT_W-1:0]  left_ff, left_in;

   // Push moves the word above into this cell, pop the word below.
   always_comb begin
      priority if (shift.push) begin
         data_in = above_data;
      end else if (shift.pop) begin
         data_in = below_data;
      end else begin
         data_in = data_ff;
      end
   end

   // The wave counts down the entries still to be folded in; once it
   // reaches zero the cell only passes the wave along.
   always_comb begin
      max_in  = scan_max_in;
      min_in  = scan_min_in;
      left_in = scan_left_in;
      if (scan_left_in != '0) begin
         if (data_ff > scan_max_in) begin
            max_in = data_ff;
         end
         if (data_ff < scan_min_in) begin
            min_in = data_ff;
         end
         left_in = scan_left_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      max_ff  <= max_in;
      min_ff  <= min_in;
      left_ff <= left_in;
   end

   assign cell_data = data_ff;
   assign scan_max  = max_ff;
   assign scan_min  = min_ff;
   assign scan_left = left_ff;

endmodule

// ===== hw/rtl/min_max_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_stack: bounded LIFO of signed words with min/max query
// A chain of DEPTH cells holds the stack, top in cell 0. Every beat returns
// the popped or peeked word (zero on push or underflow), the greatest and
// least held word, the count and the empty, full and status flags.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | req_op, req_push_value
//   rsp     | out       | rsp_valid/ready    | rsp_top_value, rsp_max_value,
//           |           |                    | rsp_min_value, rsp_entry_count,
//           |           |                    | rsp_is_empty, rsp_is_full,
//           |           |                    | rsp_status
//
// From acceptance to its response beat, a request runs thus: the stack
// shifts in the accept cycle, then a min/max wave runs one cell per cycle
// down the whole chain of DEPTH cells.
// One request is in work at a time; the next one is accepted while the
// response still waits in the output register.
// Reset empties the stack at once; the cell words need no clearing.
// A stalled response holds the scan finished until the slot frees.
// ----------------------------------------------------------------------------
module min_max_stack #(
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic        [mms_pkg::OP_W-1:0]          req_op,
   input  logic signed [mms_pkg::DATA_W-1:0]        req_push_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [mms_pkg::DATA_W-1:0]        rsp_top_value,
   output logic signed [mms_pkg::DATA_W-1:0]        rsp_max_value,
   output logic signed [mms_pkg::DATA_W-1:0]        rsp_min_value,
   output logic        [mms_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   output logic        [mms_pkg::STATUS_W-1:0]      rsp_status
);
   import mms_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_cnt_ff;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_max_ff, rsp_min_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic rsp_empty_ff, rsp_full_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   shift_type shift;
   logic req_fire;
   logic scan_done;
   logic rsp_load;

   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic signed [DATA_W-1:0] scan_max [DEPTH];
   logic signed [DATA_W-1:0] scan_min [DEPTH];
   logic [CNT_W-1:0] scan_left [DEPTH];

   assign req_ready = (state_ff == IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;

   // Decode the request beat into a shift, a new count, the top word and a status.
   always_comb begin
      shift     = '0;
      count_in  = count_ff;
      top_in    = '0;
      status_in = ST_OK;
      unique case (req_op)
         OP_PUSH: begin
            if (count_ff == FULL_COUNT) begin
               status_in = ST_OVERFLOW;
            end else begin
               shift.push = req_fire;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               shift.pop = req_fire;
               count_in  = count_ff - CNT_W'(1);
               top_in    = cell_data[0];
            end
         end
         OP_PEEK: begin
            if (count_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               top_in = cell_data[0];
            end
         end
         default: begin
         end
      endcase
   end

   // The chain of cells; cell 0 is the top of the stack and seeds the wave.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [DATA_W-1:0] above_data, below_data;
      logic signed [DATA_W-1:0] max_seed, min_seed;
      logic [CNT_W-1:0] left_seed;

      if (k == 0) begin : g_top
         assign above_data = req_push_value;
         assign max_seed   = cell_data[0];
         assign min_seed   = cell_data[0];
         assign left_seed  = count_ff;
      end else begin : g_inner
         assign above_data = cell_data[k-1];
         assign max_seed   = scan_max[k-1];
         assign min_seed   = scan_min[k-1];
         assign left_seed  = scan_left[k-1];
      end

      if (k == DEPTH - 1) begin : g_bottom
         assign below_data = cell_data[k];
      end else begin : g_upper
         assign below_data = cell_data[k+1];
      end

      mms_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock       (clock),
         .shift       (shift),
         .above_data  (above_data),
         .below_data  (below_data),
         .cell_data   (cell_data[k]),
         .scan_max_in (max_seed),
         .scan_min_in (min_seed),
         .scan_left_in(left_seed),
         .scan_max    (scan_max[k]),
         .scan_min    (scan_min[k]),
         .scan_left   (scan_left[k])
      );
   end

   // The wave has reached the bottom cell once the scan counter reaches DEPTH.
   assign scan_done = (state_ff == SCAN) && (scan_cnt_ff == FULL_COUNT);
   assign rsp_load  = scan_done && (!rsp_valid_ff || rsp_ready);

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  count_ff    <= count_in;
                  top_ff      <= top_in;
                  status_ff   <= status_in;
                  scan_cnt_ff <= '0;
                  state_ff    <= SCAN;
               end
            end
            SCAN: begin
               if (!scan_done) begin
                  scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               end else if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_top_ff    <= top_ff;
                  rsp_max_ff    <= (count_ff == '0) ? '0 : scan_max[DEPTH-1];
                  rsp_min_ff    <= (count_ff == '0) ? '0 : scan_min[DEPTH-1];
                  rsp_count_ff  <= COUNT_OUT_W'(count_ff);
                  rsp_empty_ff  <= (count_ff == '0);
                  rsp_full_ff   <= (count_ff == FULL_COUNT);
                  rsp_status_ff <= status_ff;
                  state_ff      <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
